// ===== sv/plb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types, sizes and codes for the positional list buffer.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int DEPTH     = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KIND_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int ICOUNT_W  = 5;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [VALUE_W-1:0]  slot_t;
  typedef logic [CNT_W-1:0]    count_t;

  localparam kind_t KIND_APPEND    = 2'd0;
  localparam kind_t KIND_INSERT    = 2'd1;
  localparam kind_t KIND_DROP_TAIL = 2'd2;
  localparam kind_t KIND_DROP_AT   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage
`default_nettype wire

// ===== sv/positional_list_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_buffer
// Ordered list of signed values with append, insert, remove-tail and
// remove-at requests; every request returns a status and the new count.
// From start to done a request passes the request register, then the result register.
// Throughput: one transaction per cycle; busy is always low.
// The slot array shifts the affected entries in parallel in the result cycle.
// Reset (rst, synchronous): list empty, no result pending.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module positional_list_buffer
  import plb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic [POS_W-1:0]     position,
  output logic                      done,
  output logic [STATUS_W-1:0]       status,
  output logic [ICOUNT_W-1:0]       item_count
);

  logic             req_valid;
  kind_t            req_kind;
  slot_t            req_value;
  logic [POS_W-1:0] req_position;

  slot_t   slots      [DEPTH];
  slot_t   slots_next [DEPTH];
  count_t  fill_count;
  count_t  fill_count_next;
  status_t status_next;

  logic             is_empty;
  logic             is_full;
  logic             pos_bad;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [CMP_W-1:0] cnt_ext;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    req_kind     <= kind;
    req_value    <= slot_t'(value);
    req_position <= position;
  end

  assign pos_ext  = CMP_W'(req_position);
  assign cnt_ext  = CMP_W'(fill_count);
  assign pos_m1   = pos_ext - CMP_W'(1);
  assign is_empty = (fill_count == '0);
  assign is_full  = (fill_count >= count_t'(DEPTH));
  assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);

  always_comb begin
    status_next     = ST_DONE;
    fill_count_next = fill_count;
    for (int i = 0; i < DEPTH; i++) begin
      slots_next[i] = slots[i];
    end
    case (req_kind)
      KIND_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (count_t'(i) == fill_count) slots_next[i] = req_value;
          end
          fill_count_next = fill_count + count_t'(1);
        end
      end
      KIND_INSERT: begin
        if (is_empty) begin
          slots_next[0]   = req_value;
          fill_count_next = count_t'(1);
        end else if (is_full) begin
          status_next = ST_FULL;
        end else if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == pos_m1) begin
              slots_next[i] = req_value;
            end else if (i > 0 && CMP_W'(i) > pos_m1) begin
              slots_next[i] = slots[(i > 0) ? i - 1 : 0];
            end
          end
          fill_count_next = fill_count + count_t'(1);
        end
      end
      KIND_DROP_TAIL: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          fill_count_next = fill_count - count_t'(1);
        end
      end
      KIND_DROP_AT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (CMP_W'(i) >= pos_m1) slots_next[i] = slots[i + 1];
          end
          fill_count_next = fill_count - count_t'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        fill_count <= fill_count_next;
      end
    end
    if (req_valid) begin
      for (int i = 0; i < DEPTH; i++) begin
        slots[i] <= slots_next[i];
      end
      status     <= status_next;
      item_count <= ICOUNT_W'(fill_count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= count_t'(DEPTH))
    else $error("fill count above depth");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("accepted transaction gave no result");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> item_count == ICOUNT_W'(fill_count))
    else $error("reported count differs from stored count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> item_count == '0)
    else $error("empty status with nonzero count");

endmodule
`default_nettype wire
